### hw/rtl/ttoi_pkg.sv
// Shared constants, types and character-class functions for the text to integer parser.
// Depends on nothing; every other file of the block imports it.
package ttoi_pkg;

  localparam int POS_W    = 16;
  localparam int CHAR_W   = 8;
  localparam int BASE_W   = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 16;
  localparam int PROD_W   = VALUE_W + BASE_W;
  localparam int WIDE_W   = 33;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [WIDE_W-1:0] OFFSET_MAX_WIDE = WIDE_W'({OFFSET_W{1'b1}});
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

  // Parser phases.
  localparam logic [2:0] PH_DONE   = 3'd0;
  localparam logic [2:0] PH_WS     = 3'd1;
  localparam logic [2:0] PH_SIGN   = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_ZERO_X = 3'd4;
  localparam logic [2:0] PH_DIGITS = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_CONV  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  // Radix values with a meaning of their own.
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_DEC;

  localparam logic [VALUE_W-1:0] VALUE_SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VALUE_SAT_MIN = 32'h8000_0000;

  // Characters.
  localparam logic [CHAR_W-1:0] CH_0     = "0";
  localparam logic [CHAR_W-1:0] CH_9     = "9";
  localparam logic [CHAR_W-1:0] CH_UC_A  = "A";
  localparam logic [CHAR_W-1:0] CH_UC_F  = "F";
  localparam logic [CHAR_W-1:0] CH_UC_X  = "X";
  localparam logic [CHAR_W-1:0] CH_UC_Z  = "Z";
  localparam logic [CHAR_W-1:0] CH_LC_A  = "a";
  localparam logic [CHAR_W-1:0] CH_LC_F  = "f";
  localparam logic [CHAR_W-1:0] CH_LC_X  = "x";
  localparam logic [CHAR_W-1:0] CH_LC_Z  = "z";
  localparam logic [CHAR_W-1:0] CH_PLUS  = "+";
  localparam logic [CHAR_W-1:0] CH_MINUS = "-";
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] DIGIT_NONE = 8'hFF;
  localparam logic [CHAR_W-1:0] UC_OFFSET  = CH_UC_A - 8'd10;
  localparam logic [CHAR_W-1:0] LC_OFFSET  = CH_LC_A - 8'd10;

  typedef struct packed {
    logic [2:0]         phase;
    logic [VALUE_W-1:0] acc;
    logic               negative;
    logic [BASE_W-1:0]  base;
    logic [POS_W-1:0]   position;
    logic               digit_seen;
    logic               overflowed;
    logic [POS_W-1:0]   zero_offset;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{PH_DONE, '0, 1'b0, '0, '0, 1'b0, 1'b0, '0};

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
    logic [OFFSET_W-1:0]       end_offset;
  } result_t;

  // One result item on its way to the output register.
  typedef struct packed {
    logic    emit;
    result_t res;
  } result_xfer_t;

  typedef struct packed {
    parse_state_t st;
    logic         emit;
    result_t      res;
  } step_t;

  function automatic logic is_space(logic [CHAR_W-1:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_CR, CH_FF};
  endfunction

  function automatic logic is_hex(logic [CHAR_W-1:0] c);
    return c inside {[CH_0:CH_9], [CH_UC_A:CH_UC_F], [CH_LC_A:CH_LC_F]};
  endfunction

  function automatic logic [CHAR_W-1:0] digit_of(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    if (c inside {[CH_0:CH_9]}) begin
      d = c - CH_0;
    end else if (c inside {[CH_UC_A:CH_UC_Z]}) begin
      d = c - UC_OFFSET;
    end else if (c inside {[CH_LC_A:CH_LC_Z]}) begin
      d = c - LC_OFFSET;
    end else begin
      d = DIGIT_NONE;
    end
    return d;
  endfunction

  // Closes the parse and forms the result item.
  function automatic step_t finish(parse_state_t s, logic [POS_W-1:0] e);
    step_t             r;
    logic [WIDE_W-1:0] ew;
    r          = '0;
    r.st       = s;
    r.st.phase = PH_DONE;
    r.emit     = 1'b1;
    ew         = WIDE_W'(e);
    if (s.overflowed) begin
      r.res.value  = s.negative ? VALUE_SAT_MIN : VALUE_SAT_MAX;
      r.res.status = ST_OVERFLOW;
    end else if (!s.digit_seen) begin
      r.res.value  = '0;
      r.res.status = ST_NO_CONV;
      ew           = '0;
    end else begin
      r.res.value  = s.negative ? (VALUE_W'(0) - s.acc) : s.acc;
      r.res.status = ST_OK;
    end
    r.res.end_offset = (ew > OFFSET_MAX_WIDE) ? OFFSET_MAX : ew[OFFSET_W-1:0];
    return r;
  endfunction

  // Folds one character into the accumulator, or ends the parse on a non-digit.
  function automatic step_t take_digit(parse_state_t s, logic [CHAR_W-1:0] c,
                                       logic [POS_W-1:0] p);
    step_t             r;
    logic [CHAR_W-1:0] d;
    logic [PROD_W-1:0] nxt;
    logic [PROD_W-1:0] lim;
    r    = '0;
    r.st = s;
    d    = digit_of(c);
    if (d >= CHAR_W'(s.base)) begin
      r = finish(s, s.digit_seen ? p : '0);
    end else begin
      r.st.digit_seen = 1'b1;
      if (!s.overflowed) begin
        lim = s.negative ? PROD_W'(VALUE_SAT_MIN) : PROD_W'(VALUE_SAT_MAX);
        nxt = PROD_W'(s.acc) * PROD_W'(s.base) + PROD_W'(d);
        if (nxt > lim) begin
          r.st.overflowed = 1'b1;
        end else begin
          r.st.acc = nxt[VALUE_W-1:0];
        end
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/ttoi_if.sv
// Handshake channels of the text to integer parser: characters in, results out.
// Depends on ttoi_pkg for field widths.
interface ttoi_char_if;
  import ttoi_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;
  logic              first;
  modport source (output valid, output ch, output first, input ready);
  modport sink (input valid, input ch, input first, output ready);
endinterface

interface ttoi_result_if;
  import ttoi_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [STATUS_W-1:0]       status;
  logic [OFFSET_W-1:0]       end_offset;
  modport source (output valid, output value, output status, output end_offset, input ready);
  modport sink (input valid, input value, input status, input end_offset, output ready);
endinterface

### hw/rtl/ttoi_parse.sv
// Parser state register and the per-character step logic.
// Depends on ttoi_pkg for the state type, phase codes and digit functions.
module ttoi_parse (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [ttoi_pkg::CHAR_W-1:0]   ch,
  input  logic                          first,
  input  logic [ttoi_pkg::BASE_W-1:0]   number_base,
  output ttoi_pkg::result_xfer_t        xfer
);
  import ttoi_pkg::*;

  parse_state_t     state;
  parse_state_t     state_next;
  parse_state_t     s;
  step_t            r;
  logic             active;
  logic             do_begin;
  logic             do_take;
  logic             do_fin;
  logic [POS_W-1:0] fin_end;
  logic [POS_W-1:0] p;

  always_comb begin
    s        = state;
    active   = 1'b1;
    do_begin = 1'b0;
    do_take  = 1'b0;
    do_fin   = 1'b0;
    fin_end  = '0;
    p        = '0;

    if (first) begin
      s       = STATE_RESET;
      s.phase = PH_WS;
      s.base  = number_base;
    end else if (state.phase == PH_DONE || state.phase > PH_DIGITS) begin
      s.phase = PH_DONE;
      active  = 1'b0;
    end

    if (active) begin
      p = s.position;
      if (s.position < POS_MAX) begin
        s.position = s.position + POS_W'(1);
      end
      case (s.phase)
        PH_WS: begin
          if (is_space(ch)) begin
            s.phase = PH_WS;
          end else if (ch == CH_MINUS) begin
            s.negative = 1'b1;
            s.phase    = PH_SIGN;
          end else if (ch == CH_PLUS) begin
            s.phase = PH_SIGN;
          end else begin
            do_begin = 1'b1;
          end
        end
        PH_SIGN: begin
          do_begin = 1'b1;
        end
        PH_ZERO: begin
          if (ch == CH_LC_X || ch == CH_UC_X) begin
            s.phase = PH_ZERO_X;
          end else begin
            if (s.base == BASE_AUTO) begin
              s.base = BASE_OCT;
            end
            s.digit_seen = 1'b1;
            s.phase      = PH_DIGITS;
            do_take      = 1'b1;
          end
        end
        PH_ZERO_X: begin
          if (is_hex(ch)) begin
            s.base  = BASE_HEX;
            s.phase = PH_DIGITS;
            do_take = 1'b1;
          end else begin
            // A lone "0x" counts as just the zero.
            if (s.base == BASE_AUTO) begin
              s.base = BASE_OCT;
            end
            s.digit_seen = 1'b1;
            do_fin       = 1'b1;
            fin_end      = s.zero_offset;
          end
        end
        PH_DIGITS: begin
          do_take = 1'b1;
        end
        default: begin
          s.phase = PH_DONE;
        end
      endcase

      // Start of the number proper, after white space and sign.
      if (do_begin) begin
        if (s.base == BASE_ONE || s.base > BASE_MAX) begin
          do_fin  = 1'b1;
          fin_end = '0;
        end else if ((s.base == BASE_AUTO || s.base == BASE_HEX) && ch == CH_0) begin
          s.phase       = PH_ZERO;
          s.zero_offset = s.position;
        end else begin
          if (s.base == BASE_AUTO) begin
            s.base = BASE_DEC;
          end
          s.phase = PH_DIGITS;
          do_take = 1'b1;
        end
      end
    end

    r      = '0;
    r.st   = s;
    if (do_take) begin
      r = take_digit(s, ch, p);
    end else if (do_fin) begin
      r = finish(s, fin_end);
    end

    state_next = accept ? r.st : state;
    xfer.emit  = accept & r.emit;
    xfer.res   = r.res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/ttoi_result_reg.sv
// Output register that holds one result item until the receiver takes it.
// Depends on ttoi_pkg and the ttoi_result_if channel.
module ttoi_result_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  ttoi_pkg::result_xfer_t xfer,
  output logic                   can_take,
  ttoi_result_if.source          results
);
  import ttoi_pkg::*;

  logic    valid;
  result_t hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (xfer.emit) begin
      valid <= 1'b1;
    end else if (results.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer.emit) begin
      hold <= xfer.res;
    end
  end

  // A new result may land when the slot is empty or is being emptied now.
  assign can_take           = !valid || results.ready;
  assign results.valid      = valid;
  assign results.value      = hold.value;
  assign results.status     = hold.status;
  assign results.end_offset = hold.end_offset;

endmodule

### hw/rtl/text_to_integer_parser.sv
// Top level of the streaming text to integer parser (32-bit signed, strtol rules).
// Depends on ttoi_pkg, ttoi_if, ttoi_parse and ttoi_result_reg.
//
// Usage: characters of a string enter on the chars channel, one item per
// character, with first set on the opening character of each string. The parser
// skips leading white space, takes an optional sign, honors a 0x prefix in radix 0
// and 16, and reads digits in the radix that number_base held when the string
// started. The first character that is not a digit ends the parse and produces
// one item on the results channel: the value, the status and the number of
// characters consumed. Later characters, up to the next first, are dropped.
//
// Throughput is one character per cycle; the result item is valid in the cycle
// after the terminating character is accepted. The 32 by 6 bit multiply-add of
// the accumulator and its compare against the saturation limit set the clock.
//
// While a result waits in the output register and the receiver is not ready,
// the block takes no characters at all; it resumes in the same cycle that the
// receiver takes the waiting item. Reset clears the parser to the done phase,
// empties the output register and sets number_base to 10. The user must write
// it via cfg_we and cfg_wdata only while idle; the block does not enforce this.
module text_to_integer_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ttoi_pkg::BASE_W-1:0] cfg_wdata,
  ttoi_char_if.sink                   chars,
  ttoi_result_if.source               results
);
  import ttoi_pkg::*;

  logic [BASE_W-1:0] number_base;
  logic              accept;
  logic              can_take;
  result_xfer_t      xfer;

  // The radix register; a new string latches it on its first character.
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_RESET;
    end else if (cfg_we) begin
      number_base <= cfg_wdata;
    end
  end

  // A character is taken whenever the output slot could hold any result it makes.
  assign chars.ready = can_take;
  assign accept      = chars.valid && chars.ready;

  ttoi_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .ch          (chars.ch),
    .first       (chars.first),
    .number_base (number_base),
    .xfer        (xfer)
  );

  ttoi_result_reg u_result_reg (
    .clk      (clk),
    .rst      (rst),
    .xfer     (xfer),
    .can_take (can_take),
    .results  (results)
  );

  // A result item appears only in the cycle after an accepted character.
  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(accept))
    else $error("result item appeared without an accepted character");

  // The receiver taking a result always frees the input side in the same cycle.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    results.ready |-> chars.ready)
    else $error("input stalled although the output slot is draining");

  // A failed conversion reports zero value and zero offset.
  a_no_conv_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status == ST_NO_CONV)
      |-> (results.value == '0 && results.end_offset == '0))
    else $error("no-conversion result carries a value or offset");

  // Status is one of the three defined codes whenever a result is shown.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.status == ST_OK || results.status == ST_NO_CONV
                       || results.status == ST_OVERFLOW))
    else $error("undefined status code on a result item");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the streaming text to integer parser.
// Depends on ttoi_pkg and the ttoi_char_if / ttoi_result_if interfaces of the RTL.
// Directed table, then random strings; a cycle-free predictor checks untyped results.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ttoi_pkg::*;

  // Radix settings that the package does not name but the run visits.
  localparam logic [BASE_W-1:0] BASE_BINARY    = 6'd2;
  localparam logic [BASE_W-1:0] BASE_FIRST_BAD = 6'd37;
  localparam logic [BASE_W-1:0] BASE_TOP       = 6'd63;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned HOLD_STRINGS  = 15;
  localparam int unsigned PHASE_COUNT   = 12;
  localparam int unsigned PHASE_ITEMS   = 60;
  localparam int unsigned DIRECTED_ROWS = 26;

  // A row of the directed table either writes the radix register or sends one
  // character item. Rows whose result is obvious carry it typed in.
  typedef enum bit {ROW_CHAR, ROW_BASE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [7:0]  ch;
    logic        first;
    bit          typed;
    result_t     want;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [BASE_W-1:0]   cfg_wdata;

  ttoi_char_if   chars_if ();
  ttoi_result_if results_if ();

  text_to_integer_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .chars     (chars_if),
    .results   (results_if)
  );

  // Predictor state: the parse in progress and our copy of the radix register.
  parse_state_t      parser   = STATE_RESET;
  logic [BASE_W-1:0] base_reg = BASE_RESET;

  // Conversions that the block still owes us, oldest first.
  result_t expected_conversions[$];

  int          error_count  = 0;
  int unsigned parsed_chars = 0;
  int unsigned cycle_count  = 0;

  // Shared between the sender and the receiver: a stretch with no idling on
  // either side, and a one-shot request for a long receiver hold-off.
  bit quiet_stretch = 1'b0;
  bit hold_request  = 1'b0;

  logic [7:0] blank_chars [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_CR, CH_FF};

  // The directed part. It opens at the reset radix of ten, so the first rows
  // need no register write.
  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    // A character before any start is dropped without a result.
    '{ROW_CHAR, 8'hFF,    1'b0, 1'b0, '0},
    // Leading blank, minus sign, two digits, a letter that ends the number.
    '{ROW_CHAR, CH_SPACE, 1'b1, 1'b0, '0},
    '{ROW_CHAR, CH_MINUS, 1'b0, 1'b0, '0},
    '{ROW_CHAR, "1",      1'b0, 1'b0, '0},
    '{ROW_CHAR, "2",      1'b0, 1'b0, '0},
    '{ROW_CHAR, "x",      1'b0, 1'b1, '{-32'sd12, ST_OK, 16'd4}},
    // Characters after the result are ignored until the next start.
    '{ROW_CHAR, "7",      1'b0, 1'b0, '0},
    // A start while a parse runs drops that parse with no result.
    '{ROW_CHAR, "5",      1'b1, 1'b0, '0},
    '{ROW_CHAR, "9",      1'b1, 1'b0, '0},
    '{ROW_CHAR, 8'h00,    1'b0, 1'b1, '{32'sd9, ST_OK, 16'd1}},
    // Radix 36: six letters of value 35 overflow a negative number.
    '{ROW_BASE, {2'b00, BASE_MAX}, 1'b0, 1'b0, '0},
    '{ROW_CHAR, CH_MINUS, 1'b1, 1'b0, '0},
    '{ROW_CHAR, CH_LC_Z,  1'b0, 1'b0, '0},
    '{ROW_CHAR, CH_UC_Z,  1'b0, 1'b0, '0},
    '{ROW_CHAR, CH_LC_Z,  1'b0, 1'b0, '0},
    '{ROW_CHAR, CH_UC_Z,  1'b0, 1'b0, '0},
    '{ROW_CHAR, CH_LC_Z,  1'b0, 1'b0, '0},
    '{ROW_CHAR, CH_LC_Z,  1'b0, 1'b0, '0},
    '{ROW_CHAR, 8'h00,    1'b0, 1'b1, '{VALUE_SAT_MIN, ST_OVERFLOW, 16'd7}},
    // Radix one is invalid: no conversion right after the sign.
    '{ROW_BASE, {2'b00, BASE_ONE}, 1'b0, 1'b0, '0},
    '{ROW_CHAR, CH_PLUS,  1'b1, 1'b0, '0},
    '{ROW_CHAR, "5",      1'b0, 1'b1, '{32'sd0, ST_NO_CONV, 16'd0}},
    // Automatic radix: a 0x prefix with no hex digit after it keeps the zero.
    '{ROW_BASE, {2'b00, BASE_AUTO}, 1'b0, 1'b0, '0},
    '{ROW_CHAR, CH_0,     1'b1, 1'b0, '0},
    '{ROW_CHAR, CH_UC_X,  1'b0, 1'b0, '0},
    '{ROW_CHAR, "g",      1'b0, 1'b1, '{32'sd0, ST_OK, 16'd1}}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop if the run hangs anywhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor. It walks the same phases as the block, one character at a time.
  // ---------------------------------------------------------------------------

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF ||
           c == CH_VT || c == CH_CR || c == CH_FF;
  endfunction

  function automatic bit is_hex_char(logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UC_A && c <= CH_UC_F) ||
           (c >= CH_LC_A && c <= CH_LC_F);
  endfunction

  // Value of a character as a digit in any radix up to 36; 255 for none.
  function automatic int unsigned char_digit(logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_UC_A && c <= CH_UC_Z) return int'(c - CH_UC_A) + 10;
    if (c >= CH_LC_A && c <= CH_LC_Z) return int'(c - CH_LC_A) + 10;
    return 255;
  endfunction

  // Closes the parse. A saturated value wins over everything; with no digit
  // at all the result is no conversion and the offset drops to zero.
  function automatic result_t settle_result(logic [31:0] end_pos);
    result_t     r;
    logic [31:0] e;
    e = end_pos;
    if (parser.overflowed) begin
      r.value  = parser.negative ? VALUE_SAT_MIN : VALUE_SAT_MAX;
      r.status = ST_OVERFLOW;
    end else if (!parser.digit_seen) begin
      r.value  = '0;
      r.status = ST_NO_CONV;
      e        = '0;
    end else begin
      r.value  = parser.negative ? (32'd0 - parser.acc) : parser.acc;
      r.status = ST_OK;
    end
    r.end_offset = (e > 32'hFFFF) ? 16'hFFFF : e[15:0];
    parser.phase = PH_DONE;
    return r;
  endfunction

  // Folds a digit into the value or, on a non-digit, ends the parse. Once the
  // value has overflowed, digits are still consumed but no longer added.
  task automatic fold_digit(input logic [7:0] c, input logic [15:0] p,
                            inout bit done, inout result_t r);
    int unsigned d;
    logic [63:0] nxt;
    logic [63:0] bound;
    d = char_digit(c);
    if (d >= parser.base) begin
      r    = settle_result(parser.digit_seen ? 32'(p) : 32'd0);
      done = 1'b1;
    end else begin
      parser.digit_seen = 1'b1;
      if (!parser.overflowed) begin
        bound = parser.negative ? 64'h8000_0000 : 64'h7FFF_FFFF;
        nxt   = 64'(parser.acc) * 64'(parser.base) + 64'(d);
        if (nxt > bound) parser.overflowed = 1'b1;
        else parser.acc = nxt[31:0];
      end
    end
  endtask

  // First character after the blanks and the sign.
  task automatic start_number(input logic [7:0] c, input logic [15:0] p,
                              inout bit done, inout result_t r);
    if (parser.base == BASE_ONE || parser.base > BASE_MAX) begin
      r    = settle_result(32'd0);
      done = 1'b1;
    end else if ((parser.base == BASE_AUTO || parser.base == BASE_HEX) && c == CH_0) begin
      parser.phase       = PH_ZERO;
      parser.zero_offset = (p < POS_MAX) ? p + 16'd1 : POS_MAX;
    end else begin
      if (parser.base == BASE_AUTO) parser.base = BASE_DEC;
      parser.phase = PH_DIGITS;
      fold_digit(c, p, done, r);
    end
  endtask

  // Advances the predictor by one accepted character item.
  task automatic track_char(input logic [7:0] c, input logic f,
                            output bit done, output result_t r);
    logic [15:0] p;
    done = 1'b0;
    r    = '0;
    if (f) begin
      parser             = STATE_RESET;
      parser.phase       = PH_WS;
      parser.base        = base_reg;
    end
    if (!f && (parser.phase == PH_DONE || parser.phase > PH_DIGITS)) begin
      parser.phase = PH_DONE;
    end else begin
      p = parser.position;
      if (parser.position < POS_MAX) parser.position = parser.position + 16'd1;
      case (parser.phase)
        PH_WS: begin
          if (c == CH_MINUS) begin
            parser.negative = 1'b1;
            parser.phase    = PH_SIGN;
          end else if (c == CH_PLUS) begin
            parser.phase = PH_SIGN;
          end else if (!is_blank(c)) begin
            start_number(c, p, done, r);
          end
        end
        PH_SIGN: start_number(c, p, done, r);
        PH_ZERO: begin
          if (c == CH_LC_X || c == CH_UC_X) begin
            parser.phase = PH_ZERO_X;
          end else begin
            if (parser.base == BASE_AUTO) parser.base = BASE_OCT;
            parser.digit_seen = 1'b1;
            parser.phase      = PH_DIGITS;
            fold_digit(c, p, done, r);
          end
        end
        PH_ZERO_X: begin
          if (is_hex_char(c)) begin
            parser.base  = BASE_HEX;
            parser.phase = PH_DIGITS;
            fold_digit(c, p, done, r);
          end else begin
            // The x was not a prefix after all; only the zero counts.
            if (parser.base == BASE_AUTO) parser.base = BASE_OCT;
            parser.digit_seen = 1'b1;
            r    = settle_result(32'(parser.zero_offset));
            done = 1'b1;
          end
        end
        PH_DIGITS: fold_digit(c, p, done, r);
        default: parser.phase = PH_DONE;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender side. Inputs change only with nonblocking assignments at a rising
  // edge, and handshakes are judged on the values from before that edge.
  // ---------------------------------------------------------------------------

  // Offers one character item after a random gap and waits until it is taken.
  // On acceptance the predictor advances and any result is queued. A typed
  // expectation from the directed table replaces the predicted one.
  task automatic put_char(input logic [7:0] c, input logic f,
                          input bit typed, input result_t want);
    int unsigned gap;
    bit          done;
    result_t     got;
    gap = quiet_stretch ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.ch    <= c;
    chars_if.first <= f;
    do @(posedge clk); while (chars_if.ready !== 1'b1);
    // Only items that the parser acts on count toward the phase budget.
    if (f || parser.phase != PH_DONE) parsed_chars++;
    track_char(c, f, done, got);
    if (typed) expected_conversions.push_back(want);
    else if (done) expected_conversions.push_back(got);
  endtask

  // Stops sending and waits until every owed result has arrived, then lets the
  // block settle in case an ignored character is still inside it.
  task automatic drain_results();
    chars_if.valid <= 1'b0;
    while (expected_conversions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Radix writes happen only with the block idle.
  task automatic set_base(input logic [BASE_W-1:0] b);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we    <= 1'b0;
    base_reg   = b;
  endtask

  function automatic logic [7:0] digit_char(int unsigned d);
    if (d < 10) return CH_0 + 8'(d);
    return ($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + 8'(d - 10);
  endfunction

  // Builds and sends one number string in the current radix: blanks, an optional sign,
  // maybe a 0x prefix, digits that are mostly valid, then a character that
  // ends the number. Some strings are left open so that the next start cuts
  // them off, and some get trailing characters that must be ignored. One in
  // six carries a magnitude right at the edge of the 32-bit range.
  task automatic send_number_string();
    logic [7:0]  text[$];
    logic [7:0]  digits_rev[$];
    logic [63:0] mag;
    int unsigned radix;
    bit          prefixed;
    bit          open_end;
    repeat ($urandom_range(0, 3)) text.push_back(blank_chars[$urandom_range(0, 5)]);
    case ($urandom_range(0, 3))
      0: text.push_back(CH_MINUS);
      1: text.push_back(CH_PLUS);
      default: ;
    endcase
    if (base_reg == BASE_AUTO || base_reg == BASE_HEX) prefixed = 1'($urandom_range(0, 1));
    else prefixed = ($urandom_range(0, 7) == 0);
    if (prefixed) begin
      text.push_back(CH_0);
      text.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
    end
    if (base_reg >= BASE_BINARY && base_reg <= BASE_MAX) begin
      radix = 32'(base_reg);
    end else if (prefixed) begin
      radix = 16;
    end else if (base_reg == BASE_AUTO && $urandom_range(0, 2) == 0) begin
      // A leading zero switches the automatic radix to octal.
      text.push_back(CH_0);
      radix = 8;
    end else begin
      radix = 10;
    end
    if ($urandom_range(0, 5) == 0) begin
      mag = 64'h7FFF_FFFF + 64'($urandom_range(0, 2));
      do begin
        digits_rev.push_front(digit_char(int'(mag % 64'(radix))));
        mag = mag / 64'(radix);
      end while (mag != 0);
      foreach (digits_rev[i]) text.push_back(digits_rev[i]);
    end else begin
      repeat ($urandom_range(0, (radix == 2) ? 34 : 12))
        text.push_back(digit_char($urandom_range(0, radix - 1)));
    end
    open_end = 1'b0;
    case ($urandom_range(0, 7))
      0: open_end = 1'b1;
      1, 2: text.push_back(8'h00);
      3, 4: text.push_back(8'($urandom_range(0, 255)));
      5: text.push_back(CH_SPACE);
      6: text.push_back(".");
      default: text.push_back(CH_UC_Z);
    endcase
    foreach (text[i]) put_char(text[i], i == 0, 1'b0, '0);
    if (!open_end && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) put_char(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
  endtask

  // Main stimulus: reset, directed table, then random phases across radix
  // settings, then the verdict.
  initial begin
    logic [BASE_W-1:0] phase_bases [9];
    logic [BASE_W-1:0] b;
    int unsigned       phase_start;
    phase_bases = '{BASE_DEC, BASE_AUTO, BASE_HEX, BASE_BINARY, BASE_OCT,
                    BASE_MAX, BASE_ONE, BASE_TOP, BASE_FIRST_BAD};
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    chars_if.valid <= 1'b0;
    chars_if.ch    <= '0;
    chars_if.first <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_BASE) begin
        set_base(directed_rows[i].ch[BASE_W-1:0]);
      end else begin
        put_char(directed_rows[i].ch, directed_rows[i].first,
                 directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int k = 0; k < PHASE_COUNT; k++) begin
      b = (k < 9) ? phase_bases[k] : BASE_W'($urandom_range(0, 63));
      set_base(b);
      if (k == 0) begin
        // The receiver stops for a long while at its next item; the sender
        // keeps streaming short strings with no gaps so the block backs up.
        hold_request  = 1'b1;
        quiet_stretch = 1'b1;
        repeat (HOLD_STRINGS) send_number_string();
      end
      phase_start = parsed_chars;
      while (parsed_chars - phase_start < PHASE_ITEMS) begin
        quiet_stretch = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 9) == 0) begin
          // Noise: raw bytes with a random start flag.
          repeat ($urandom_range(1, 4))
            put_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          send_number_string();
        end
      end
      quiet_stretch = 1'b0;
      // A NUL ends any parse still open, so the next radix write finds the
      // block idle.
      if (parser.phase != PH_DONE) put_char(8'h00, 1'b0, 1'b0, '0);
    end

    drain_results();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: a random stall before each result item, plus one long hold-off
  // counted here when the stimulus asks for it.
  initial begin
    int unsigned stall;
    results_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        results_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = quiet_stretch ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        results_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (results_if.valid !== 1'b1);
    end
  end

  // Every result item taken is compared with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
      if (expected_conversions.size() == 0) begin
        $error("result item with nothing expected: value %0d status %0d end_offset %0d",
               results_if.value, results_if.status, results_if.end_offset);
        error_count++;
      end else begin
        want = expected_conversions.pop_front();
        if (results_if.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, results_if.value);
          error_count++;
        end
        if (results_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, results_if.status);
          error_count++;
        end
        if (results_if.end_offset !== want.end_offset) begin
          $error("end_offset: expected %0d, got %0d", want.end_offset,
                 results_if.end_offset);
          error_count++;
        end
      end
    end
  end

endmodule
